// ----- hw/rtl/psm_pkg.sv -----
// ----------------------------------------------------------------------------
// psm_pkg
// Shared types and constants of the pressure sliding median core.
// ----------------------------------------------------------------------------
package psm_pkg;

  localparam int unsigned SampleW = 17;
  localparam int unsigned MedianW = 18;
  localparam int unsigned CountW  = 5;
  localparam int unsigned InDataW = 24;
  localparam int unsigned OutDataW = 24;
  localparam int unsigned OutUserW = 2;

  localparam logic [0:0] CfgMinPressure = 1'b0;
  localparam logic [0:0] CfgMaxPressure = 1'b1;

  localparam logic [SampleW-1:0] MinPressureRst = 17'd30000;
  localparam logic [SampleW-1:0] MaxPressureRst = 17'd110000;

  // controller to datapath
  typedef struct packed {
    logic take_in;
    logic ins_init;
    logic rd_old;
    logic find_init;
    logic rd_idx;
    logic idx_inc;
    logic dir_set;
    logic rd_nb;
    logic shift;
    logic place;
    logic rd_med_a;
    logic rd_med_b;
    logic med_sum;
    logic med_zero;
    logic load_out;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic acc;
    logic full;
    logic fill_zero;
    logic eq_old;
    logic at_edge;
    logic sh_cond;
    logic out_free;
  } sts_t;

endpackage

// ----- hw/rtl/psm_ctrl.sv -----
// ----------------------------------------------------------------------------
// psm_ctrl
// Sequencer: range check, sorted-list replace or insert, median read-out.
// ----------------------------------------------------------------------------
module psm_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  psm_pkg::sts_t  sts_i,
  output psm_pkg::cmd_t  cmd_o
);

  localparam logic [3:0] StIdle  = 4'd0;
  localparam logic [3:0] StStart = 4'd1;
  localparam logic [3:0] StOld   = 4'd2;
  localparam logic [3:0] StFdRd  = 4'd3;
  localparam logic [3:0] StFdEv  = 4'd4;
  localparam logic [3:0] StShRd  = 4'd5;
  localparam logic [3:0] StShEv  = 4'd6;
  localparam logic [3:0] StPlace = 4'd7;
  localparam logic [3:0] StMedRd = 4'd8;
  localparam logic [3:0] StMedA  = 4'd9;
  localparam logic [3:0] StMedB  = 4'd10;
  localparam logic [3:0] StFin   = 4'd11;

  logic [3:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.take_in = 1'b1;
          state_d       = StStart;
        end
      end
      StStart: begin
        if (!sts_i.acc) begin
          state_d = StMedRd;
        end else if (sts_i.full) begin
          cmd_o.rd_old = 1'b1;
          state_d      = StOld;
        end else begin
          cmd_o.ins_init = 1'b1;
          state_d        = StShRd;
        end
      end
      StOld: begin
        cmd_o.find_init = 1'b1;
        state_d         = StFdRd;
      end
      StFdRd: begin
        cmd_o.rd_idx = 1'b1;
        state_d      = StFdEv;
      end
      StFdEv: begin
        if (sts_i.eq_old) begin
          cmd_o.dir_set = 1'b1;
          state_d       = StShRd;
        end else begin
          cmd_o.idx_inc = 1'b1;
          state_d       = StFdRd;
        end
      end
      StShRd: begin
        if (sts_i.at_edge) begin
          state_d = StPlace;
        end else begin
          cmd_o.rd_nb = 1'b1;
          state_d     = StShEv;
        end
      end
      StShEv: begin
        if (sts_i.sh_cond) begin
          cmd_o.shift = 1'b1;
          state_d     = StShRd;
        end else begin
          state_d = StPlace;
        end
      end
      StPlace: begin
        cmd_o.place = 1'b1;
        state_d     = StMedRd;
      end
      StMedRd: begin
        if (sts_i.fill_zero) begin
          cmd_o.med_zero = 1'b1;
          state_d        = StFin;
        end else begin
          cmd_o.rd_med_a = 1'b1;
          state_d        = StMedA;
        end
      end
      StMedA: begin
        cmd_o.rd_med_b = 1'b1;
        state_d        = StMedB;
      end
      StMedB: begin
        cmd_o.med_sum = 1'b1;
        state_d       = StFin;
      end
      StFin: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- hw/rtl/psm_dp.sv -----
// ----------------------------------------------------------------------------
// psm_dp
// Datapath: limit registers, circular window, sorted copy, median and output.
// ----------------------------------------------------------------------------
module psm_dp #(
  parameter int unsigned WINDOW = 30
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [0:0]                     cfg_idx_i,
  input  logic [psm_pkg::SampleW-1:0]    cfg_data_i,
  input  logic [psm_pkg::SampleW-1:0]    sample_i,
  input  psm_pkg::cmd_t                  cmd_i,
  output psm_pkg::sts_t                  sts_o,
  input  logic                           out_ready_i,
  output logic                           out_valid_o,
  output logic [psm_pkg::MedianW-1:0]    median_o,
  output logic                           median_valid_o,
  output logic [psm_pkg::CountW-1:0]     count_o,
  output logic                           accepted_o
);

  localparam int unsigned IdxW = $clog2(WINDOW);
  localparam int unsigned CntW = $clog2(WINDOW + 1);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(WINDOW - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(WINDOW);

  logic [psm_pkg::SampleW-1:0] min_q, max_q;
  logic [psm_pkg::SampleW-1:0] smp_q, old_q, med_a_q;
  logic                        acc_q, dir_up_q;
  logic [IdxW-1:0]             idx_q, wp_q, nb;
  logic [CntW-1:0]             fill_q, fill_m1;

  logic [psm_pkg::SampleW-1:0] win_mem [WINDOW];
  logic [psm_pkg::SampleW-1:0] srt_mem [WINDOW];
  logic [psm_pkg::SampleW-1:0] win_rdata_q, srt_rdata_q;
  logic [IdxW-1:0]             srt_raddr;
  logic                        srt_re;
  logic                        srt_we;
  logic [psm_pkg::SampleW-1:0] srt_wdata;

  logic                        out_valid_q;
  logic [psm_pkg::MedianW-1:0] med_q, out_med_q;
  logic                        out_mv_q, out_acc_q;
  logic [psm_pkg::CountW-1:0]  out_cnt_q;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q <= psm_pkg::MinPressureRst;
      max_q <= psm_pkg::MaxPressureRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        psm_pkg::CfgMinPressure: min_q <= cfg_data_i;
        psm_pkg::CfgMaxPressure: max_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign nb      = dir_up_q ? idx_q + 1'b1 : idx_q - 1'b1;
  assign fill_m1 = fill_q - CntW'(1);

  // sorted-list port
  always_comb begin
    srt_re    = 1'b1;
    srt_raddr = idx_q;
    priority if (cmd_i.rd_nb) begin
      srt_raddr = nb;
    end else if (cmd_i.rd_med_a) begin
      srt_raddr = IdxW'(fill_m1 >> 1);
    end else if (cmd_i.rd_med_b) begin
      srt_raddr = IdxW'(fill_q >> 1);
    end else if (cmd_i.rd_idx) begin
      srt_raddr = idx_q;
    end else begin
      srt_re = 1'b0;
    end
  end

  assign srt_we    = cmd_i.shift | cmd_i.place;
  assign srt_wdata = cmd_i.shift ? srt_rdata_q : smp_q;

  always_ff @(posedge clk_i) begin
    if (srt_re) begin
      srt_rdata_q <= srt_mem[srt_raddr];
    end
    if (srt_we) begin
      srt_mem[idx_q] <= srt_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_old) begin
      win_rdata_q <= win_mem[wp_q];
    end
    if (cmd_i.place) begin
      win_mem[wp_q] <= smp_q;
    end
  end

  // item payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.take_in) begin
      smp_q <= sample_i;
      acc_q <= (sample_i >= min_q) && (sample_i <= max_q);
    end
    if (cmd_i.find_init) begin
      old_q <= win_rdata_q;
    end
    if (cmd_i.ins_init) begin
      idx_q    <= IdxW'(fill_q);
      dir_up_q <= 1'b0;
    end else if (cmd_i.find_init) begin
      idx_q <= '0;
    end else if (cmd_i.idx_inc) begin
      idx_q <= idx_q + 1'b1;
    end else if (cmd_i.shift) begin
      idx_q <= nb;
    end
    if (cmd_i.dir_set) begin
      dir_up_q <= smp_q > old_q;
    end
    if (cmd_i.rd_med_b) begin
      med_a_q <= srt_rdata_q;
    end
    if (cmd_i.med_zero) begin
      med_q <= '0;
    end else if (cmd_i.med_sum) begin
      med_q <= {1'b0, med_a_q} + {1'b0, srt_rdata_q};
    end
  end

  // window position and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q   <= '0;
      fill_q <= '0;
    end else if (cmd_i.place) begin
      wp_q <= (wp_q == LastIdx) ? '0 : wp_q + 1'b1;
      if (fill_q != FullCnt) begin
        fill_q <= fill_q + 1'b1;
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_med_q <= med_q;
      out_mv_q  <= fill_q != '0;
      out_cnt_q <= psm_pkg::CountW'(fill_q);
      out_acc_q <= acc_q;
    end
  end

  assign sts_o.acc       = acc_q;
  assign sts_o.full      = fill_q == FullCnt;
  assign sts_o.fill_zero = fill_q == '0;
  // last entry doubles as a guard against a missing match
  assign sts_o.eq_old    = (srt_rdata_q == old_q) || (idx_q == LastIdx);
  assign sts_o.at_edge   = dir_up_q ? (idx_q == LastIdx) : (idx_q == '0);
  assign sts_o.sh_cond   = dir_up_q ? (srt_rdata_q < smp_q) : (srt_rdata_q > smp_q);
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  assign out_valid_o    = out_valid_q;
  assign median_o       = out_med_q;
  assign median_valid_o = out_mv_q;
  assign count_o        = out_cnt_q;
  assign accepted_o     = out_acc_q;

endmodule

// ----- hw/rtl/pressure_sliding_median_core.sv -----
// ----------------------------------------------------------------------------
// The time from an input transaction to its result transaction is set, for an
// accepted sample, by the sorted-list search and shift, which step through the
// entries on its single read port; a rejected sample skips both.
// Flow control: one sample in work at a time;
// the next is taken once the result sits in the output register.
// Reset: limits return to defaults, window empties; window RAM is not cleared.
// ----------------------------------------------------------------------------
// pressure_sliding_median_core
// Sliding-window median of barometric pressure samples, in half units.
// ----------------------------------------------------------------------------
module pressure_sliding_median_core #(
  parameter int unsigned WINDOW = 30
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [0:0]                      cfg_idx_i,
  input  logic [psm_pkg::SampleW-1:0]     cfg_data_i,
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  input  logic [psm_pkg::InDataW-1:0]     s_axis_tdata_i,   // sample[16:0], zero pad
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  output logic [psm_pkg::OutDataW-1:0]    m_axis_tdata_o,   // median_half_units[17:0],
                                                            // sample_count[22:18], zero pad
  output logic [psm_pkg::OutUserW-1:0]    m_axis_tuser_o    // median_valid[0],
                                                            // sample_accepted[1]
);

  psm_pkg::cmd_t cmd;
  psm_pkg::sts_t sts;

  logic [psm_pkg::MedianW-1:0] median;
  logic                        median_valid;
  logic [psm_pkg::CountW-1:0]  count;
  logic                        accepted;

  psm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  psm_dp #(
    .WINDOW (WINDOW)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .sample_i       (s_axis_tdata_i[psm_pkg::SampleW-1:0]),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .out_ready_i    (m_axis_tready_i),
    .out_valid_o    (m_axis_tvalid_o),
    .median_o       (median),
    .median_valid_o (median_valid),
    .count_o        (count),
    .accepted_o     (accepted)
  );

  assign m_axis_tdata_o = {1'b0, count, median};
  assign m_axis_tuser_o = {accepted, median_valid};

`ifndef ASSERT_OFF
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("second transaction taken while one is in work");

  a_valid_matches_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tuser_o[0] == (m_axis_tdata_o[22:18] != 5'd0))
                        || (WINDOW > 31))
    else $error("median valid flag disagrees with sample count");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (WINDOW > 31) || (32'(m_axis_tdata_o[22:18]) <= WINDOW))
    else $error("sample count above window size");

  a_single_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.shift, cmd.place, cmd.load_out}))
    else $error("conflicting datapath writes");
`endif

endmodule
